// ----- rtl/nps_pkg.sv -----
// shared types and constants of the nearest point search block
package nps_pkg;

  localparam int MAX_NODES = 256;
  localparam int IDX_W     = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CNT_W     = $clog2(MAX_NODES + 1);

  localparam int FUNC_W  = 2;
  localparam int ID_W    = 16;
  localparam int COORD_W = 24;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int SQ_W    = 2 * COORD_W;
  localparam int DIST_W  = SQ_W + 1;

  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;

  typedef struct packed {
    logic [ID_W-1:0]           id;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] z;
  } point_t;

  typedef struct packed {
    logic start;
    logic sample;
  } dist_ctl_t;

  typedef struct packed {
    logic            found;
    logic [ID_W-1:0] id;
  } dist_res_t;

endpackage

// ----- rtl/nps_req_if.sv -----
// request channel: operation code, point identifier and position
interface nps_req_if;
  logic                                valid;
  logic                                ready;
  logic [nps_pkg::FUNC_W-1:0]          func;
  logic [nps_pkg::ID_W-1:0]            point_id;
  logic signed [nps_pkg::COORD_W-1:0]  pos_x;
  logic signed [nps_pkg::COORD_W-1:0]  pos_z;

  modport source (output valid, func, point_id, pos_x, pos_z, input ready);
  modport sink   (input valid, func, point_id, pos_x, pos_z, output ready);
endinterface

// ----- rtl/nps_rsp_if.sv -----
// response channel: nearest identifier and status flags
interface nps_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [nps_pkg::ID_W-1:0]   nearest_id;
  logic                       found;
  logic                       table_full;

  modport source (output valid, nearest_id, found, table_full, input ready);
  modport sink   (input valid, nearest_id, found, table_full, output ready);
endinterface

// ----- rtl/nps_cell.sv -----
// one storage cell of the point chain
module nps_cell (
  input  logic            clk,
  input  logic            shift,
  input  nps_pkg::point_t d,
  output nps_pkg::point_t q
);

  always_ff @(posedge clk) begin
    if (shift) begin
      q <= d;
    end
  end

endmodule

// ----- rtl/nps_dist.sv -----
// pipelined squared distance unit with running minimum
module nps_dist (
  input  logic                               clk,
  input  logic                               rst,
  input  nps_pkg::dist_ctl_t                 ctl,
  input  nps_pkg::point_t                    head,
  input  logic signed [nps_pkg::COORD_W-1:0] qx,
  input  logic signed [nps_pkg::COORD_W-1:0] qz,
  output nps_pkg::dist_res_t                 res
);

  logic signed [nps_pkg::DIFF_W-1:0]   dx;
  logic signed [nps_pkg::DIFF_W-1:0]   dz;
  logic                                s0_tag;
  logic [nps_pkg::ID_W-1:0]            s0_id;
  logic signed [2*nps_pkg::DIFF_W-1:0] px;
  logic signed [2*nps_pkg::DIFF_W-1:0] pz;
  logic [nps_pkg::SQ_W-1:0]            sqx;
  logic [nps_pkg::SQ_W-1:0]            sqz;
  logic                                s1_tag;
  logic [nps_pkg::ID_W-1:0]            s1_id;
  logic [nps_pkg::DIST_W-1:0]          sum;
  logic                                have;
  logic [nps_pkg::DIST_W-1:0]          best_d;
  logic [nps_pkg::ID_W-1:0]            best_id;

  assign px  = dx * dx;
  assign pz  = dz * dz;
  assign sum = {1'b0, sqx} + {1'b0, sqz};

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_tag <= 1'b0;
      s1_tag <= 1'b0;
      have   <= 1'b0;
    end else begin
      s0_tag <= ctl.sample;
      s1_tag <= s0_tag;
      if (ctl.start) begin
        have <= 1'b0;
      end else if (s1_tag && (!have || sum < best_d)) begin
        // strict compare keeps the earlier point on a tie
        have    <= 1'b1;
        best_d  <= sum;
        best_id <= s1_id;
      end
    end
    dx    <= {head.x[nps_pkg::COORD_W-1], head.x} - {qx[nps_pkg::COORD_W-1], qx};
    dz    <= {head.z[nps_pkg::COORD_W-1], head.z} - {qz[nps_pkg::COORD_W-1], qz};
    s0_id <= head.id;
    sqx   <= px[nps_pkg::SQ_W-1:0];
    sqz   <= pz[nps_pkg::SQ_W-1:0];
    s1_id <= s0_id;
  end

  assign res.found = have;
  assign res.id    = have ? best_id : '0;

endmodule

// ----- rtl/nearest_point_search_top.sv -----
// nearest point search: point table in a chain of cells with a linear nearest scan
//
// Points live in a chain of MAX_NODES cells; an append shifts the new point into the
// head of the chain and a clear resets the point count. A query rotates the whole
// chain once past a single three-stage squared distance unit and then waits in a
// drain state while the last point passes through it before its response is ready;
// clears, appends, unused codes and queries of an empty table put their response in
// the holding register when they are taken. A finished response sits in a holding
// register and then in the output register, so one more request is taken while a
// response waits; each response moves to the output register once the output is
// free or being read. No clearing pass is needed after reset.
module nearest_point_search_top (
  input logic        clk,
  input logic        rst,
  nps_req_if.sink    req,
  nps_rsp_if.source  rsp
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  typedef struct packed {
    logic [nps_pkg::ID_W-1:0] nearest_id;
    logic                     found;
    logic                     table_full;
  } rsp_t;

  localparam logic [1:0] DRAIN_LAST = 2'd2;

  state_t                             state;
  logic [nps_pkg::CNT_W-1:0]          cnt;
  logic [nps_pkg::IDX_W-1:0]          t;
  logic [1:0]                         drain;
  logic signed [nps_pkg::COORD_W-1:0] qx;
  logic signed [nps_pkg::COORD_W-1:0] qz;
  logic                               pend_valid;
  rsp_t                               pend;
  logic                               out_valid;
  rsp_t                               out;

  nps_pkg::point_t    cell_q [nps_pkg::MAX_NODES];
  nps_pkg::point_t    chain_in;
  nps_pkg::point_t    new_pt;
  nps_pkg::dist_ctl_t ctl;
  nps_pkg::dist_res_t res;

  logic                      accept;
  logic                      is_full;
  logic                      app_ok;
  logic                      scan;
  logic                      shift;
  logic [nps_pkg::CNT_W-1:0] lead;

  assign req.ready = (state == ST_IDLE) && !pend_valid;
  assign accept    = req.valid && req.ready;
  assign is_full   = (cnt == nps_pkg::CNT_W'(nps_pkg::MAX_NODES));
  assign app_ok    = accept && (req.func == nps_pkg::FUNC_APPEND) && !is_full;
  assign scan      = (state == ST_SCAN);
  assign shift     = app_ok || scan;

  assign new_pt.id = req.point_id;
  assign new_pt.x  = req.pos_x;
  assign new_pt.z  = req.pos_z;
  // the scan rotates the chain, so it is back in place after a full turn
  assign chain_in  = scan ? cell_q[nps_pkg::MAX_NODES-1] : new_pt;

  genvar i;
  generate
    for (i = 0; i < nps_pkg::MAX_NODES; i++) begin : g_cell
      if (i == 0) begin : g_head
        nps_cell u_cell (.clk(clk), .shift(shift), .d(chain_in), .q(cell_q[i]));
      end else begin : g_body
        nps_cell u_cell (.clk(clk), .shift(shift), .d(cell_q[i-1]), .q(cell_q[i]));
      end
    end
  endgenerate

  // the tail shows stored points oldest first once t reaches MAX_NODES - cnt
  assign lead       = nps_pkg::CNT_W'(nps_pkg::MAX_NODES) - cnt;
  assign ctl.sample = scan && (nps_pkg::CNT_W'(t) >= lead);
  assign ctl.start  = accept && (req.func == nps_pkg::FUNC_QUERY);

  nps_dist u_dist (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl),
    .head (cell_q[nps_pkg::MAX_NODES-1]),
    .qx   (qx),
    .qz   (qz),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cnt        <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            pend.nearest_id <= '0;
            pend.found      <= 1'b0;
            pend.table_full <= (req.func == nps_pkg::FUNC_APPEND) && is_full;
            case (req.func)
              nps_pkg::FUNC_CLEAR: begin
                cnt        <= '0;
                pend_valid <= 1'b1;
              end
              nps_pkg::FUNC_APPEND: begin
                pend_valid <= 1'b1;
                if (!is_full) begin
                  cnt <= cnt + nps_pkg::CNT_W'(1);
                end
              end
              nps_pkg::FUNC_QUERY: begin
                if (cnt == '0) begin
                  pend_valid <= 1'b1;
                end else begin
                  state <= ST_SCAN;
                  t     <= '0;
                  qx    <= req.pos_x;
                  qz    <= req.pos_z;
                end
              end
              default: begin
                pend_valid <= 1'b1;
              end
            endcase
          end
        end
        ST_SCAN: begin
          t <= t + nps_pkg::IDX_W'(1);
          if (t == nps_pkg::IDX_W'(nps_pkg::MAX_NODES - 1)) begin
            state <= ST_DRAIN;
            drain <= '0;
          end
        end
        ST_DRAIN: begin
          drain <= drain + 2'd1;
          if (drain == DRAIN_LAST) begin
            pend_valid      <= 1'b1;
            pend.nearest_id <= res.id;
            pend.found      <= res.found;
            pend.table_full <= 1'b0;
            state           <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      if (pend_valid && (!out_valid || rsp.ready)) begin
        out_valid  <= 1'b1;
        out        <= pend;
        pend_valid <= 1'b0;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.nearest_id = out.nearest_id;
  assign rsp.found      = out.found;
  assign rsp.table_full = out.table_full;

endmodule

// ----- rtl/nps_checker.sv -----
// port-level checks of the nearest point search block and their binding
module nps_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             req_valid,
  input logic                             req_ready,
  input logic [nps_pkg::FUNC_W-1:0]       req_func,
  input logic                             rsp_valid,
  input logic                             rsp_ready,
  input logic [nps_pkg::ID_W-1:0]         rsp_nearest_id,
  input logic                             rsp_found,
  input logic                             rsp_table_full
);

  logic req_acc;
  assign req_acc = req_valid && req_ready;

  // a stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_nearest_id)
      && $stable(rsp_found) && $stable(rsp_table_full))
    else $error("response changed while stalled");

  a_flags: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp_found && rsp_table_full))
    else $error("found and table_full both set");

  a_no_id: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_found |-> rsp_nearest_id == '0)
    else $error("identifier set without a found point");

  // table updates answer through the holding and output registers when the output is free
  a_update_rsp: assert property (@(posedge clk) disable iff (rst)
    req_acc && !rsp_valid
      && (req_func == nps_pkg::FUNC_CLEAR || req_func == nps_pkg::FUNC_APPEND)
      |=> ##1 rsp_valid && !rsp_found)
    else $error("table update response missing");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    req_acc && req_func == nps_pkg::FUNC_QUERY |=> !req_ready)
    else $error("request taken right after a query");

endmodule

bind nearest_point_search_top nps_checker u_nps_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .req_func       (req.func),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_nearest_id (rsp.nearest_id),
  .rsp_found      (rsp.found),
  .rsp_table_full (rsp.table_full)
);

// ----- bench/tb.sv -----
// testbench for the nearest point search block: directed corner cases, then random point tables and queries
`timescale 1ns / 100ps

module tb;

  typedef logic signed [nps_pkg::COORD_W-1:0] coord_t;
  typedef logic [nps_pkg::ID_W-1:0] id_t;
  typedef logic [nps_pkg::FUNC_W-1:0] func_t;

  localparam func_t FUNC_UNUSED = 2'd3;
  localparam coord_t COORD_MIN = {1'b1, {(nps_pkg::COORD_W-1){1'b0}}};
  localparam coord_t COORD_MAX = {1'b0, {(nps_pkg::COORD_W-1){1'b1}}};
  localparam int RANDOM_REQUESTS = 1900;
  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 700;

  class nearest_sb;
    typedef struct {
      id_t  id;
      logic found;
      logic full;
    } answer_t;

    id_t         ids[nps_pkg::MAX_NODES];
    coord_t      xs[nps_pkg::MAX_NODES];
    coord_t      zs[nps_pkg::MAX_NODES];
    int unsigned count;
    answer_t     pending_answers[$];
    int          errors;

    function new();
      count = 0;
      errors = 0;
    endfunction

    // works out the answer of one accepted request and updates the point table
    function void note_request(func_t f, id_t id, coord_t x, coord_t z);
      answer_t a;
      longint  best, d2, dx, dz;
      a.id = '0;
      a.found = 1'b0;
      a.full = 1'b0;
      best = 0;
      case (f)
        nps_pkg::FUNC_CLEAR: count = 0;
        nps_pkg::FUNC_APPEND: begin
          if (count >= nps_pkg::MAX_NODES) begin
            a.full = 1'b1;
          end else begin
            ids[count] = id;
            xs[count] = x;
            zs[count] = z;
            count++;
          end
        end
        nps_pkg::FUNC_QUERY: begin
          for (int i = 0; i < count; i++) begin
            dx = longint'(x) - longint'(xs[i]);
            dz = longint'(z) - longint'(zs[i]);
            d2 = dx * dx + dz * dz;
            // only a strictly nearer point replaces the earlier one
            if (!a.found || d2 < best) begin
              a.found = 1'b1;
              best = d2;
              a.id = ids[i];
            end
          end
        end
        default: ;
      endcase
      pending_answers = {pending_answers, a};
    endfunction

    task report_mismatch(string what);
      errors++;
      if (errors <= 100) $display("%0t mismatch: %s", $realtime, what);
    endtask

    task check_response(id_t id, logic found, logic full);
      answer_t a;
      if (pending_answers.size() == 0) begin
        report_mismatch("response with no request pending");
        return;
      end
      a = pending_answers.pop_front();
      if (id !== a.id)
        report_mismatch($sformatf("nearest_id %h, wanted %h", id, a.id));
      if (found !== a.found)
        report_mismatch($sformatf("found %b, wanted %b", found, a.found));
      if (full !== a.full)
        report_mismatch($sformatf("table_full %b, wanted %b", full, a.full));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;

  nps_req_if req_ch();
  nps_rsp_if rsp_ch();

  nearest_point_search_top dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch.sink),
    .rsp (rsp_ch.source)
  );

  nearest_sb sb = new();
  int burst_left = 0;
  int requests_sent = 0;
  int quiet_cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // mix of extremes, wide values and a tight cluster that gives many ties
  function automatic coord_t rand_coord();
    case ($urandom_range(0, 9))
      0: return COORD_MIN;
      1: return COORD_MAX;
      2, 3: return coord_t'($urandom);
      4, 5: return coord_t'(int'($urandom_range(0, 4096)) - 2048);
      default: return coord_t'(int'($urandom_range(0, 24)) - 12);
    endcase
  endfunction

  task automatic send_item(input func_t f, input id_t id,
                           input coord_t x, input coord_t z);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req_ch.valid <= 1'b1;
    req_ch.func <= f;
    req_ch.point_id <= id;
    req_ch.pos_x <= x;
    req_ch.pos_z <= z;
    do @(posedge clk); while (!req_ch.ready);
    sb.note_request(f, id, x, z);
    if (f != FUNC_UNUSED) requests_sent++;
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (sb.pending_answers.size() != 0);
  endtask

  initial begin : stimulus
    int seg, n_ops, pick, extra;
    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.func <= nps_pkg::FUNC_CLEAR;
    req_ch.point_id <= '0;
    req_ch.pos_x <= '0;
    req_ch.pos_z <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_item(nps_pkg::FUNC_QUERY, '0, COORD_MAX, COORD_MIN);       // empty table
    send_item(FUNC_UNUSED, '1, '1, '1);
    send_item(nps_pkg::FUNC_APPEND, '1, COORD_MAX, COORD_MAX);
    send_item(nps_pkg::FUNC_APPEND, '0, COORD_MIN, COORD_MIN);
    send_item(nps_pkg::FUNC_QUERY, '1, COORD_MIN, COORD_MIN);
    send_item(nps_pkg::FUNC_QUERY, '0, COORD_MAX, COORD_MAX);
    send_item(nps_pkg::FUNC_QUERY, 16'h7777, '0, '0);
    send_item(nps_pkg::FUNC_QUERY, '0, COORD_MAX, COORD_MIN);
    send_item(nps_pkg::FUNC_APPEND, 16'h1234, 24'sd10, '0);
    send_item(nps_pkg::FUNC_APPEND, 16'h4321, -24'sd10, '0);
    send_item(nps_pkg::FUNC_APPEND, 16'h5555, 24'sd10, '0);
    send_item(nps_pkg::FUNC_QUERY, '0, '0, '0);                     // three equidistant points
    send_item(nps_pkg::FUNC_QUERY, '0, 24'sd10, '0);                // duplicate position
    send_item(nps_pkg::FUNC_CLEAR, '1, COORD_MAX, COORD_MAX);
    send_item(nps_pkg::FUNC_QUERY, '0, '0, '0);
    send_item(nps_pkg::FUNC_APPEND, 16'hA5A5, -24'sd1, 24'sd1);
    send_item(nps_pkg::FUNC_QUERY, 16'h5A5A, COORD_MIN, COORD_MAX);
    send_item(FUNC_UNUSED, '0, '0, '0);
    send_item(nps_pkg::FUNC_QUERY, '0, -24'sd1, 24'sd1);
    drain();

    requests_sent = 0;
    seg = 0;
    while (requests_sent < RANDOM_REQUESTS) begin
      if (seg == 1 || seg == 20 || $urandom_range(0, 59) == 0) begin
        // fill to capacity, then push past it
        send_item(nps_pkg::FUNC_CLEAR, id_t'($urandom), rand_coord(), rand_coord());
        while (sb.count < nps_pkg::MAX_NODES) begin
          if ($urandom_range(0, 39) == 0)
            send_item(nps_pkg::FUNC_QUERY, id_t'($urandom), rand_coord(), rand_coord());
          else
            send_item(nps_pkg::FUNC_APPEND, id_t'($urandom), rand_coord(), rand_coord());
        end
        extra = $urandom_range(1, 4);
        repeat (extra) begin
          send_item(nps_pkg::FUNC_APPEND, id_t'($urandom), rand_coord(), rand_coord());
          if ($urandom_range(0, 1) == 0)
            send_item(nps_pkg::FUNC_QUERY, id_t'($urandom), rand_coord(), rand_coord());
        end
      end else begin
        if ($urandom_range(0, 2) == 0)
          send_item(nps_pkg::FUNC_CLEAR, id_t'($urandom), rand_coord(), rand_coord());
        n_ops = $urandom_range(1, 14);
        repeat (n_ops) begin
          pick = $urandom_range(0, 19);
          if (pick < 10)
            send_item(nps_pkg::FUNC_APPEND, id_t'($urandom), rand_coord(), rand_coord());
          else if (pick < 17)
            send_item(nps_pkg::FUNC_QUERY, id_t'($urandom), rand_coord(), rand_coord());
          else if (pick < 18)
            send_item(nps_pkg::FUNC_CLEAR, id_t'($urandom), rand_coord(), rand_coord());
          else
            send_item(FUNC_UNUSED, id_t'($urandom), rand_coord(), rand_coord());
        end
      end
      if ($urandom_range(0, 24) == 0) drain();
      seg++;
    end

    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("PASS nearest_point_search_top");
    end else begin
      $display("FAIL nearest_point_search_top");
    end
    $finish;
  end

  initial begin : receiver
    int mode, mode_left, hold_left, took, held_at, phase;
    logic rdy;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    took = 0;
    held_at = -1;
    phase = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid && rsp_ch.ready) begin
        sb.check_response(rsp_ch.nearest_id, rsp_ch.found, rsp_ch.table_full);
        took++;
      end
      phase++;
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if ((took == 60 || took == 400) && held_at != took) begin
        // long hold so the block backs up into the request side
        held_at = took;
        hold_left = HOLD_CYCLES;
        rdy = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(8, 80);
        end
        mode_left--;
        case (mode)
          0: rdy = 1'b1;
          1: rdy = 1'($urandom_range(0, 1));
          2: rdy = (phase % 3) != 0;
          default: rdy = $urandom_range(0, 7) == 0;
        endcase
      end
      rsp_ch.ready <= rdy;
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("FAIL nearest_point_search_top");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
